[src/assert_macros.svh]
// Assertion helper macros shared by the RTL modules.
// Needs nothing else; each module includes it by file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

[src/ftda_pkg.sv]
// Shared constants, types and character codes for the float-to-decimal text block.
// No dependencies.
`timescale 1ns / 1ps

package ftda_pkg;

    localparam int TEXT_LIMIT          = 15;
    localparam int MAX_FRACTION_DIGITS = 7;
    localparam int MAX_RESULTS         = 14;

    localparam int EXP_BIAS   = 127;
    localparam int MANT_BITS  = 23;
    localparam int FRAC_BITS  = MANT_BITS + 1;
    localparam int INT_BITS   = 31;
    localparam int BCD_DIGITS = 10;
    localparam int BCD_W      = BCD_DIGITS * 4;
    localparam int CHAR_W     = 7;

    localparam int DIG_IDX_W  = $clog2(BCD_DIGITS);
    localparam int CNT_W      = $clog2(INT_BITS);
    localparam int FCNT_W     = $clog2(MAX_FRACTION_DIGITS + 1);
    localparam int FIDX_W     = (MAX_FRACTION_DIGITS > 1) ? $clog2(MAX_FRACTION_DIGITS) : 1;

    localparam logic [7:0] EXP_ERR     = 8'(EXP_BIAS + INT_BITS);
    localparam logic [7:0] EXP_INT_ALL = 8'(EXP_BIAS + MANT_BITS);
    localparam logic [7:0] EXP_ONE     = 8'(EXP_BIAS);

    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
    localparam logic [CHAR_W-1:0] CH_POINT = 7'h2E;
    localparam logic [CHAR_W-1:0] CH_NONE  = 7'h00;

    typedef logic [BCD_DIGITS-1:0][3:0] bcd_t;
    typedef logic [MAX_FRACTION_DIGITS-1:0][3:0] fdig_t;

    typedef enum logic [1:0] {
        OP_DABBLE  = 2'b01,
        OP_TIMES10 = 2'b10
    } op_t;

    // Unpacked view of one input value
    typedef struct packed {
        logic                 err;
        logic                 sign;
        logic                 frac_zero;
        logic [INT_BITS-1:0]  ip;
        logic [FRAC_BITS-1:0] frac;
    } dec_t;

endpackage

[src/ftda_decode.sv]
// Splits a single precision bit pattern into sign, integer part and 24-bit fraction.
// Depends on ftda_pkg.
`timescale 1ns / 1ps

module ftda_decode (
    input  logic [31:0]     value_bits,
    output ftda_pkg::dec_t  dec
);
    import ftda_pkg::*;

    logic [7:0]           ef;
    logic [FRAC_BITS-1:0] mant;
    logic [2:0]           sh_up;
    logic [4:0]           sh_int;
    logic [4:0]           sh_frac;
    logic [7:0]           sh_low;

    assign ef      = value_bits[30:23];
    assign mant    = {1'b1, value_bits[22:0]};
    assign sh_up   = 3'(ef - EXP_INT_ALL);
    assign sh_int  = 5'(EXP_INT_ALL - ef);
    assign sh_frac = 5'(ef - EXP_ONE + 8'd1);
    assign sh_low  = EXP_ONE - 8'd1 - ef;

    always_comb
    begin
        dec.err       = (ef >= EXP_ERR);
        dec.sign      = value_bits[31] & (ef != 8'd0);
        dec.ip        = '0;
        dec.frac      = '0;
        if (ef == 8'd0)
        begin
            dec.sign = 1'b0;
        end
        else if (ef >= EXP_INT_ALL)
        begin
            dec.ip = {{(INT_BITS-FRAC_BITS){1'b0}}, mant} << sh_up;
        end
        else if (ef >= EXP_ONE)
        begin
            dec.ip   = INT_BITS'(mant >> sh_int);
            dec.frac = mant << sh_frac;
        end
        else if (sh_low < 8'(FRAC_BITS))
        begin
            dec.frac = mant >> sh_low;
        end
        dec.frac_zero = (dec.frac == '0);
    end

endmodule

[src/ftda_step_unit.sv]
// Shared shift/add unit: one double-dabble step, or one times-ten fraction step.
// Depends on ftda_pkg.
`timescale 1ns / 1ps

module ftda_step_unit (
    input  ftda_pkg::op_t                       op,
    input  ftda_pkg::bcd_t                      bcd_in,
    input  logic [ftda_pkg::INT_BITS-1:0]       bin_in,
    input  logic [ftda_pkg::FRAC_BITS-1:0]      frac_in,
    output ftda_pkg::bcd_t                      bcd_out,
    output logic [ftda_pkg::INT_BITS-1:0]       bin_out,
    output logic [ftda_pkg::FRAC_BITS-1:0]      frac_out,
    output logic [3:0]                          digit
);
    import ftda_pkg::*;

    bcd_t                   corr;
    logic [BCD_W-1:0]       flat;
    logic [FRAC_BITS+3:0]   prod;

    always_comb
    begin
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            corr[i] = (bcd_in[i] >= 4'd5) ? bcd_in[i] + 4'd3 : bcd_in[i];
        end
    end

    assign flat = corr;
    // x10 as (x << 3) + (x << 1); the top nibble is the next decimal digit
    assign prod = ({4'b0, frac_in} << 3) + ({4'b0, frac_in} << 1);

    always_comb
    begin
        bcd_out  = bcd_in;
        bin_out  = bin_in;
        frac_out = frac_in;
        digit    = 4'd0;
        case (op)
            OP_DABBLE:
            begin
                bcd_out = {flat[BCD_W-2:0], bin_in[INT_BITS-1]};
                bin_out = {bin_in[INT_BITS-2:0], 1'b0};
            end
            OP_TIMES10:
            begin
                digit    = prod[FRAC_BITS+3:FRAC_BITS];
                frac_out = prod[FRAC_BITS-1:0];
            end
            default:
            begin
                digit = 4'd0;
            end
        endcase
    end

endmodule

[src/float_to_decimal_ascii.sv]
// Top level: sequencer that turns a single precision value into decimal ASCII text.
// Depends on ftda_pkg, ftda_decode, ftda_step_unit and assert_macros.svh.
//
// Usage:
//   Drive value_bits and raise start; the transfer happens at a clock edge where
//   start is high and busy is low. busy then stays high until the last character
//   has been registered for output.
//   Each character appears on char_code/last_char/range_error for one cycle with
//   char_valid high; the receiver has no way to hold it. last_char marks the end.
//   Magnitudes of 2^31 or more, infinities and NaNs give one character with
//   range_error set, the cycle after the transfer; busy does not rise.
//   Otherwise: a double-dabble pass on the shared step unit, one step per integer
//   bit, then a planning state, one times-ten step per fraction digit (0 to 7
//   fraction digits) and the output of the characters (3 to 14 characters). A new
//   transfer is accepted only once busy is low again. The dabble loop on the
//   shared unit is the longest of these phases.
//   Reset returns the sequencer to idle and drops char_valid; no clearing pass.
`timescale 1ns / 1ps

module float_to_decimal_ascii (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [31:0]                    value_bits,
    output logic                           char_valid,
    output logic [ftda_pkg::CHAR_W-1:0]    char_code,
    output logic                           last_char,
    output logic                           range_error
);
    import ftda_pkg::*;

`include "assert_macros.svh"

    typedef enum logic [7:0] {
        S_IDLE   = 8'b00000001,
        S_DABBLE = 8'b00000010,
        S_PLAN   = 8'b00000100,
        S_FRAC   = 8'b00001000,
        S_SIGN   = 8'b00010000,
        S_INT    = 8'b00100000,
        S_POINT  = 8'b01000000,
        S_EFRAC  = 8'b10000000
    } state_t;

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   valid_reg, valid_next;

    logic                   sign_reg, sign_next;
    logic                   fzero_reg, fzero_next;
    bcd_t                   bcd_reg, bcd_next;
    logic [INT_BITS-1:0]    bin_reg, bin_next;
    logic [FRAC_BITS-1:0]   frac_reg, frac_next;
    fdig_t                  fdig_reg, fdig_next;
    logic [DIG_IDX_W-1:0]   idx_reg, idx_next;
    logic [FCNT_W-1:0]      fi_reg, fi_next;
    logic [FCNT_W-1:0]      lim_reg, lim_next;
    logic [FCNT_W-1:0]      keep_reg, keep_next;
    logic [CHAR_W-1:0]      char_reg, char_next;
    logic                   last_reg, last_next;
    logic                   err_reg, err_next;

    dec_t                   dec;
    op_t                    op;
    bcd_t                   u_bcd;
    logic [INT_BITS-1:0]    u_bin;
    logic [FRAC_BITS-1:0]   u_frac;
    logic [3:0]             u_digit;

    logic [DIG_IDX_W-1:0]   top;
    logic [FCNT_W-1:0]      lim_c;
    state_t                 first_emit;
    int                     n_pre;
    int                     lim_i;

    ftda_decode u_decode (
        .value_bits (value_bits),
        .dec        (dec)
    );

    assign op = (state_reg == S_FRAC) ? OP_TIMES10 : OP_DABBLE;

    ftda_step_unit u_step (
        .op       (op),
        .bcd_in   (bcd_reg),
        .bin_in   (bin_reg),
        .frac_in  (frac_reg),
        .bcd_out  (u_bcd),
        .bin_out  (u_bin),
        .frac_out (u_frac),
        .digit    (u_digit)
    );

    // Leading nonzero digit; an all-zero integer part still prints one '0'
    always_comb
    begin
        top = '0;
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            if (bcd_reg[i] != 4'd0)
            begin
                top = DIG_IDX_W'(i);
            end
        end
    end

    // Fraction digit budget from the characters already committed
    always_comb
    begin
        n_pre = int'(sign_reg) + int'(top) + 2;
        lim_i = TEXT_LIMIT - 1 - n_pre;
        if (MAX_RESULTS - n_pre < lim_i)
        begin
            lim_i = MAX_RESULTS - n_pre;
        end
        if (MAX_FRACTION_DIGITS < lim_i)
        begin
            lim_i = MAX_FRACTION_DIGITS;
        end
        if (lim_i < 0)
        begin
            lim_i = 0;
        end
        lim_c = FCNT_W'(lim_i);
    end

    assign first_emit = sign_reg ? S_SIGN : S_INT;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        valid_next = 1'b0;
        sign_next  = sign_reg;
        fzero_next = fzero_reg;
        bcd_next   = bcd_reg;
        bin_next   = bin_reg;
        frac_next  = frac_reg;
        fdig_next  = fdig_reg;
        idx_next   = idx_reg;
        fi_next    = fi_reg;
        lim_next   = lim_reg;
        keep_next  = keep_reg;
        char_next  = CH_NONE;
        last_next  = 1'b0;
        err_next   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (dec.err)
                    begin
                        valid_next = 1'b1;
                        last_next  = 1'b1;
                        err_next   = 1'b1;
                    end
                    else
                    begin
                        sign_next  = dec.sign;
                        fzero_next = dec.frac_zero;
                        bin_next   = dec.ip;
                        frac_next  = dec.frac;
                        bcd_next   = '0;
                        cnt_next   = CNT_W'(INT_BITS - 1);
                        state_next = S_DABBLE;
                    end
                end
            end
            S_DABBLE:
            begin
                bcd_next = u_bcd;
                bin_next = u_bin;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = S_PLAN;
                end
            end
            S_PLAN:
            begin
                idx_next  = top;
                fdig_next = '0;
                fi_next   = '0;
                lim_next  = lim_c;
                keep_next = '0;
                if (fzero_reg)
                begin
                    keep_next  = FCNT_W'(1);
                    state_next = first_emit;
                end
                else if (lim_c == '0)
                begin
                    state_next = first_emit;
                end
                else
                begin
                    state_next = S_FRAC;
                end
            end
            S_FRAC:
            begin
                frac_next = u_frac;
                fdig_next[fi_reg[FIDX_W-1:0]] = u_digit;
                if (u_digit != 4'd0)
                begin
                    keep_next = fi_reg + 1'b1;
                end
                if (fi_reg == lim_reg - 1'b1)
                begin
                    // trailing zeros drop, but one fraction digit stays
                    if ((u_digit == 4'd0) && (keep_reg == '0))
                    begin
                        keep_next = FCNT_W'(1);
                    end
                    fi_next    = '0;
                    state_next = first_emit;
                end
                else
                begin
                    fi_next = fi_reg + 1'b1;
                end
            end
            S_SIGN:
            begin
                valid_next = 1'b1;
                char_next  = CH_MINUS;
                state_next = S_INT;
            end
            S_INT:
            begin
                valid_next = 1'b1;
                char_next  = CH_ZERO + {3'b0, bcd_reg[idx_reg]};
                if (idx_reg == '0)
                begin
                    state_next = S_POINT;
                end
                else
                begin
                    idx_next = idx_reg - 1'b1;
                end
            end
            S_POINT:
            begin
                valid_next = 1'b1;
                char_next  = CH_POINT;
                fi_next    = '0;
                if (keep_reg == '0)
                begin
                    last_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_EFRAC;
                end
            end
            S_EFRAC:
            begin
                valid_next = 1'b1;
                char_next  = CH_ZERO + {3'b0, fdig_reg[fi_reg[FIDX_W-1:0]]};
                if (fi_reg == keep_reg - 1'b1)
                begin
                    last_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    fi_next = fi_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sign_reg  <= sign_next;
        fzero_reg <= fzero_next;
        bcd_reg   <= bcd_next;
        bin_reg   <= bin_next;
        frac_reg  <= frac_next;
        fdig_reg  <= fdig_next;
        idx_reg   <= idx_next;
        fi_reg    <= fi_next;
        lim_reg   <= lim_next;
        keep_reg  <= keep_next;
        char_reg  <= char_next;
        last_reg  <= last_next;
        err_reg   <= err_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign char_valid  = valid_reg;
    assign char_code   = char_reg;
    assign last_char   = last_reg;
    assign range_error = err_reg;

    `ASSERT_NEXT(a_err_single, clk, rst_n, start && !busy && dec.err,
                 char_valid && range_error && last_char && !busy)
    `ASSERT_IMPLIES(a_err_blank, clk, rst_n, char_valid && range_error,
                    char_code == CH_NONE)
    `ASSERT_IMPLIES(a_more_busy, clk, rst_n, char_valid && !last_char, busy)
    `ASSERT_NEXT(a_dabble_done, clk, rst_n, (state_reg == S_DABBLE) && (cnt_reg == '0),
                 state_reg == S_PLAN)

endmodule
